// ===== src/anp_pkg.sv =====
`default_nettype none

package anp_pkg;

   // Widths and digit-count limits of the parser.
   localparam int VALUE_BITS     = 32;
   localparam int MAX_HEX_DIGITS = 8;
   localparam int MAX_DEC_DIGITS = 12;
   localparam int CHAR_BITS      = 8;
   localparam int POS_BITS       = 8;
   localparam int DIGIT_BITS     = 4;

   // Result word on the stream: value, then status, padded to whole bytes.
   localparam int RSP_PAYLOAD_BITS = VALUE_BITS + 1;
   localparam int RSP_DATA_BITS    = ((RSP_PAYLOAD_BITS + 7) / 8) * 8;

   localparam logic [POS_BITS-1:0] POS_MAX   = {POS_BITS{1'b1}};
   localparam logic [POS_BITS-1:0] POS_ZERO  = '0;
   localparam logic [POS_BITS-1:0] POS_ONE   = POS_BITS'(1);
   localparam logic [POS_BITS-1:0] POS_TWO   = POS_BITS'(2);
   localparam logic [POS_BITS-1:0] HEX_LIMIT = POS_BITS'(MAX_HEX_DIGITS + 2);
   localparam logic [POS_BITS-1:0] DEC_LIMIT = POS_BITS'(MAX_DEC_DIGITS);

   // Characters with a meaning of their own.
   localparam logic [CHAR_BITS-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_X = 8'h78;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_F = 8'h66;

   // Radix of the string, decided by its second character.
   typedef enum logic [1:0] {
      MODE_UNDECIDED = 2'd0,
      MODE_DEC       = 2'd1,
      MODE_HEX       = 2'd2
   } anp_mode_type;

   typedef struct packed {
      logic                  ok;
      logic [DIGIT_BITS-1:0] val;
   } anp_digit_type;

   typedef struct packed {
      logic                  status;
      logic [VALUE_BITS-1:0] value;
   } anp_result_type;

   // Digit value of a character; hex letters count only in hex mode.
   function automatic anp_digit_type anp_digit(input logic [CHAR_BITS-1:0] c,
                                               input logic hex);
      anp_digit_type d;
      d.ok  = 1'b0;
      d.val = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d.ok  = 1'b1;
         d.val = DIGIT_BITS'(c - CHAR_ZERO);
      end else if (hex && c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         d.ok  = 1'b1;
         d.val = DIGIT_BITS'(c - CHAR_UPPER_A + 8'd10);
      end else if (hex && c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         d.ok  = 1'b1;
         d.val = DIGIT_BITS'(c - CHAR_LOWER_A + 8'd10);
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== src/anp_core.sv =====
`default_nettype none

module anp_core
   import anp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [CHAR_BITS-1:0] character,
   output logic                      res_valid,
   output anp_result_type            res
);

   logic [POS_BITS-1:0]   pos_ff,   pos_in;
   logic [CHAR_BITS-1:0]  held_ff,  held_in;
   anp_mode_type          mode_ff,  mode_in;
   logic [VALUE_BITS-1:0] acc_ff,   acc_in;
   logic                  bad_ff,   bad_in;

   anp_mode_type          mode_eff;
   logic [VALUE_BITS-1:0] acc_eff;
   logic                  bad_eff;
   logic [VALUE_BITS-1:0] acc_next;
   logic [POS_BITS-1:0]   pos_inc;
   anp_digit_type         held_digit;
   anp_digit_type         cur_digit;
   logic                  is_x;
   logic                  is_nul;
   logic                  count_bad;

   // State as it stands once a pending first character has been fed in decimal.
   always_comb begin
      held_digit = anp_digit(held_ff, 1'b0);
      if (mode_ff == MODE_UNDECIDED) begin
         mode_eff = MODE_DEC;
         acc_eff  = held_digit.ok ? VALUE_BITS'(held_digit.val) : '0;
         bad_eff  = !held_digit.ok;
      end else begin
         mode_eff = mode_ff;
         acc_eff  = acc_ff;
         bad_eff  = bad_ff;
      end
   end

   // Accumulate the current character: shift by four in hex, times ten in decimal.
   always_comb begin
      cur_digit = anp_digit(character, mode_eff == MODE_HEX);
      if (mode_eff == MODE_HEX) begin
         acc_next = (acc_eff << 4) | VALUE_BITS'(cur_digit.val);
      end else begin
         acc_next = (acc_eff << 3) + (acc_eff << 1) + VALUE_BITS'(cur_digit.val);
      end
      pos_inc = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POS_ONE;
      is_x    = (character == CHAR_LOWER_X) || (character == CHAR_UPPER_X);
      is_nul  = (character == CHAR_NUL);
      if (mode_eff == MODE_HEX) begin
         count_bad = (pos_ff == POS_TWO) || (pos_ff > HEX_LIMIT);
      end else begin
         count_bad = (pos_ff > DEC_LIMIT);
      end
   end

   // Next state and the result on the terminating NUL.
   always_comb begin
      pos_in     = pos_ff;
      held_in    = held_ff;
      mode_in    = mode_ff;
      acc_in     = acc_ff;
      bad_in     = bad_ff;
      res_valid  = 1'b0;
      res.value  = '0;
      res.status = 1'b0;
      if (step) begin
         if (pos_ff == POS_ZERO) begin
            if (is_nul) begin
               res_valid = 1'b1;
            end else begin
               held_in = character;
               pos_in  = POS_ONE;
            end
         end else if (mode_ff == MODE_UNDECIDED && is_x) begin
            mode_in = MODE_HEX;
            pos_in  = pos_inc;
         end else if (is_nul) begin
            res_valid  = 1'b1;
            res.value  = acc_eff;
            res.status = bad_eff || count_bad;
            pos_in     = POS_ZERO;
            held_in    = '0;
            mode_in    = MODE_UNDECIDED;
            acc_in     = '0;
            bad_in     = 1'b0;
         end else begin
            mode_in = mode_eff;
            pos_in  = pos_inc;
            acc_in  = acc_eff;
            bad_in  = bad_eff;
            if (!bad_eff) begin
               if (cur_digit.ok) begin
                  acc_in = acc_next;
               end else begin
                  bad_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_ZERO;
         held_ff <= '0;
         mode_ff <= MODE_UNDECIDED;
         acc_ff  <= '0;
         bad_ff  <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         held_ff <= held_in;
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         bad_ff  <= bad_in;
      end
   end

`ifndef SYNTHESIS
   // A result always leaves the parser ready for a fresh string.
   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> (pos_ff == POS_ZERO) && (mode_ff == MODE_UNDECIDED))
      else $error("parser state not cleared after result");

   // The radix is only known once two characters have been seen.
   a_mode_needs_two: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_UNDECIDED) |-> (pos_ff >= POS_TWO))
      else $error("radix decided before second character");

   // Nothing accumulates before the first character.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (pos_ff == POS_ZERO) |-> (acc_ff == '0) && !bad_ff)
      else $error("accumulator not empty at string start");

   // An error freezes the accumulator until the string ends.
   a_frozen_on_error: assert property (@(posedge clock) disable iff (reset)
      (bad_ff && step && !is_nul) |=> $stable(acc_ff))
      else $error("accumulator moved after a bad character");
`endif

endmodule

`default_nettype wire

// ===== src/ascii_number_parser.sv =====
// Channel  Direction  Payload (low bit first)            Handshake
// req_     in         tdata[7:0] character               tvalid / tready
// rsp_     out        tdata[31:0] value, [32] status     tvalid / tready
//
// One character is taken per cycle while req_tready is high; each result is registered on rsp_.
// The cycle time is set by the times-ten add on the 32-bit accumulator.
// Reset (synchronous, active high) clears the parse state and both result slots.
// A two-entry output buffer (result register plus skid slot) sits on rsp_;
// req_tready drops only while both slots hold results.

`default_nettype none

module ascii_number_parser
   import anp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [CHAR_BITS-1:0]     req_tdata,   // [7:0] character
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata    // [31:0] value, [32] status, rest zero
);

   logic           req_accept;
   logic           res_valid;
   anp_result_type res;

   logic           out_valid_ff,  out_valid_in;
   anp_result_type out_ff,        out_in;
   logic           skid_valid_ff, skid_valid_in;
   anp_result_type skid_ff,       skid_in;
   logic           pop;

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;

   anp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (req_accept),
      .character (req_tdata),
      .res_valid (res_valid),
      .res       (res)
   );

   // Output register refills from the skid slot first, else from a new result.
   always_comb begin
      pop           = out_valid_ff && rsp_tready;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_in       = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(out_ff);

`ifndef SYNTHESIS
   // The skid slot is only ever filled behind a waiting result.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot holds a result while output register is empty");

   // A stalled result with a full skid slot stays put.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_tready) |=> skid_valid_ff && $stable(out_ff))
      else $error("buffered result lost during stall");
`endif

endmodule

`default_nettype wire
